### rtl/core/piecewise_linear_curve_table_defines.svh
// Assertion helpers used by the curve table RTL.
`ifndef PIECEWISE_LINEAR_CURVE_TABLE_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PWLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PWLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pwlc_pkg.sv
package pwlc_pkg;

    localparam int ENTRIES_DEF = 256;

    localparam int KEY_W      = 16;
    localparam int VAL_W      = 16;
    localparam int STEP_W     = 9;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W      = 16;

    localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_STEP    = 3'd4;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

### rtl/core/piecewise_linear_curve_table.sv
// Piecewise-linear tone curve held as a table of ENTRIES values plus a mark bit per
// entry for control points; both live in RAMs with a registered read.
// Command channel: an item is taken when start is high and busy is low. Commands:
// init, set point, remove point, get value. Every item gives exactly one result word
// on o_value/o_status, shown for one cycle with o_done; the receiver cannot stall.
// Config channel: i_cfg_valid/o_cfg_ready with register index and data; o_cfg_ready
// is always high. Write registers only while busy is low.
// Set runs a serial key divide; set and remove both run a serial slope divide, a
// neighbor scan over the mark RAM (one entry per cycle) and a refill of each touched
// segment (one entry per cycle). Get is a table read; init refills the whole table.
// One item is in flight at a time.
// Reset: synchronous, active low. After it the block sweeps every entry of both RAMs
// (table to zero, marks at both ends) with busy high.
module piecewise_linear_curve_table #(
    parameter int ENTRIES = pwlc_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pwlc_pkg::CMD_W-1:0]          i_command,
    input  logic [pwlc_pkg::KEY_W-1:0]          i_key,
    input  logic [pwlc_pkg::VAL_W-1:0]          i_new_value,
    output logic                                o_done,
    output logic [pwlc_pkg::VAL_W-1:0]          o_value,
    output logic                                o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwlc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pwlc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

`include "piecewise_linear_curve_table_defines.svh"

    localparam int KW = pwlc_pkg::KEY_W;
    localparam int VW = pwlc_pkg::VAL_W;
    localparam int SW = pwlc_pkg::STEP_W;
    localparam int DW = pwlc_pkg::DIV_W;
    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [KW-1:0] LAST_MAX = KW'(ENTRIES - 1);
    localparam logic [IW-1:0] RST_LAST = (ENTRIES - 1 < 255) ? IW'(ENTRIES - 1) : IW'(255);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_GETRD, S_RMCHK, S_DIVK, S_SETRD, S_SETCHK,
        S_SRCH, S_RDA, S_RDB, S_SEGSET, S_SEGDIV, S_FILL, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        FL_SET_PREV, FL_SET_NEXT, FL_RM_PREV, FL_RM_NEXT
    } t_flow;

    t_state r_state;
    t_flow  r_flow;

    // config
    logic [KW-1:0] r_dom_lo, r_dom_hi;
    logic [VW-1:0] r_rng_lo, r_rng_hi;
    logic [SW-1:0] r_key_step;

    // item context
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [IW-1:0] r_idx, r_a, r_b, r_i, r_len, r_r, r_dr;
    logic [VW-1:0] r_va, r_q, r_dq;
    logic          r_neg;
    logic [IW-1:0] r_scan, r_chk_addr;
    logic          r_chk_vld, r_dir_next;
    logic [IW-1:0] r_clr_ptr, r_fill_last;
    logic [VW-1:0] r_fill_val;
    logic          r_clr_resp;
    logic          r_done, r_status;
    logic [VW-1:0] r_out_value;

    // RAM ports
    logic          tbl_we, mark_we, mark_wdata;
    logic [IW-1:0] tbl_waddr, tbl_raddr, mark_waddr, mark_raddr;
    logic [VW-1:0] tbl_wdata, tbl_rdata;
    logic          mark_rdata;

    pwlc_pkg::t_div_req div_req;
    pwlc_pkg::t_div_rsp div_rsp;

    // derived
    logic [KW-1:0] w_span, w_top, w_key_off, w_kr, w_kc, w_kc_off;
    logic [IW-1:0] w_last, w_key_idx, w_len, w_found_idx;
    logic [SW-1:0] w_step;
    logic [KW:0]   w_set_lim;
    logic          w_accept, w_in_dom, w_set_rej, w_rm_rej, w_same, w_found;
    logic [VW:0]   w_d, w_dneg;
    logic [VW-1:0] w_absd, w_fill_wr;
    logic [IW:0]   w_rsum;
    logic          w_rge;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_value     = r_out_value;
    assign o_status    = r_status;

    always_comb begin
        w_span = r_dom_hi - r_dom_lo;
        if (r_dom_hi <= r_dom_lo) begin
            w_last = '0;
        end else if (w_span > LAST_MAX) begin
            w_last = LAST_IDX;
        end else begin
            w_last = w_span[IW-1:0];
        end
        w_top     = r_dom_lo + KW'(w_last);
        w_step    = (r_key_step == '0) ? SW'(1) : r_key_step;
        w_set_lim = {1'b0, w_top} + (KW+1)'(w_step) - (KW+1)'(1);
        w_in_dom  = (i_key >= r_dom_lo) && (i_key <= w_top);
        w_key_off = i_key - r_dom_lo;
        w_key_idx = w_key_off[IW-1:0];
        w_set_rej = (i_key < r_dom_lo) || ({1'b0, i_key} > w_set_lim)
                 || (i_new_value < r_rng_lo) || (i_new_value > r_rng_hi);
        w_rm_rej  = !w_in_dom || (w_key_idx == '0) || (w_key_idx == w_last);

        // key rounded down to the step, then clamped into the domain
        w_kr = r_key - div_rsp.rem;
        if (w_kr < r_dom_lo) begin
            w_kc = r_dom_lo;
        end else if (w_kr > w_top) begin
            w_kc = w_top;
        end else begin
            w_kc = w_kr;
        end
        w_kc_off = w_kc - r_dom_lo;

        w_same = (mark_rdata || (r_idx == '0) || (r_idx == w_last)) && (tbl_rdata == r_val);

        // slope magnitude and sign of the segment
        w_d    = {1'b0, tbl_rdata} - {1'b0, r_va};
        w_dneg = -w_d;
        w_absd = w_d[VW] ? w_dneg[VW-1:0] : w_d[VW-1:0];
        w_len  = r_b - r_a;

        // incremental line: q + r/len tracks |d|*(i-a)/len
        w_fill_wr = r_neg ? (r_va - r_q) : (r_va + r_q);
        w_rsum    = {1'b0, r_r} + {1'b0, r_dr};
        w_rge     = w_rsum >= {1'b0, r_len};

        // neighbor scan over the mark RAM
        w_found     = 1'b0;
        w_found_idx = r_scan;
        if (r_chk_vld && mark_rdata) begin
            w_found     = 1'b1;
            w_found_idx = r_chk_addr;
        end else if (r_dir_next ? (r_scan == w_last) : (r_scan == '0)) begin
            w_found = 1'b1;
        end
    end

    always_comb begin
        tbl_raddr  = r_idx;
        mark_raddr = r_scan;
        tbl_we     = 1'b0;
        tbl_waddr  = r_i;
        tbl_wdata  = w_fill_wr;
        mark_we    = 1'b0;
        mark_waddr = r_idx;
        mark_wdata = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = w_absd;
        div_req.divisor  = DW'(w_len);
        unique case (r_state)
            S_IDLE: begin
                tbl_raddr        = w_key_idx;
                mark_raddr       = w_key_idx;
                div_req.start    = w_accept && (i_command == pwlc_pkg::CMD_SET) && !w_set_rej;
                div_req.dividend = i_key;
                div_req.divisor  = DW'(w_step);
            end
            S_SETRD: begin
                tbl_raddr  = r_idx;
                mark_raddr = r_idx;
            end
            S_CLR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = r_clr_ptr;
                tbl_wdata  = r_fill_val;
                mark_we    = 1'b1;
                mark_waddr = r_clr_ptr;
                mark_wdata = (r_clr_ptr == '0) || (r_clr_ptr == r_fill_last);
            end
            S_SETCHK: begin
                tbl_we     = !w_same;
                tbl_waddr  = r_idx;
                tbl_wdata  = r_val;
                mark_we    = !w_same;
                mark_wdata = 1'b1;
            end
            S_RMCHK: begin
                mark_we = mark_rdata;
            end
            S_RDA:    tbl_raddr = r_a;
            S_RDB:    tbl_raddr = r_b;
            S_SEGSET: div_req.start = 1'b1;
            S_FILL:   tbl_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_flow      <= FL_SET_PREV;
            r_clr_ptr   <= '0;
            r_fill_val  <= '0;
            r_fill_last <= RST_LAST;
            r_clr_resp  <= 1'b0;
            r_done      <= 1'b0;
            r_status    <= 1'b0;
            r_out_value <= '0;
            r_chk_vld   <= 1'b0;
            r_dir_next  <= 1'b0;
            r_dom_lo    <= '0;
            r_dom_hi    <= KW'(255);
            r_rng_lo    <= '0;
            r_rng_hi    <= VW'(255);
            r_key_step  <= SW'(1);
        end else begin
            r_done <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pwlc_pkg::REG_DOMAIN_LOW:  r_dom_lo   <= i_cfg_data;
                    pwlc_pkg::REG_DOMAIN_HIGH: r_dom_hi   <= i_cfg_data;
                    pwlc_pkg::REG_RANGE_LOW:   r_rng_lo   <= i_cfg_data;
                    pwlc_pkg::REG_RANGE_HIGH:  r_rng_hi   <= i_cfg_data;
                    pwlc_pkg::REG_KEY_STEP:    r_key_step <= i_cfg_data[SW-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr_ptr <= r_clr_ptr + IW'(1);
                    if (r_clr_ptr == LAST_IDX) begin
                        r_state <= r_clr_resp ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_key       <= i_key;
                        r_val       <= i_new_value;
                        r_idx       <= w_key_idx;
                        r_out_value <= '0;
                        r_status    <= 1'b0;
                        unique case (i_command)
                            pwlc_pkg::CMD_INIT: begin
                                r_clr_ptr   <= '0;
                                r_fill_val  <= r_rng_lo;
                                r_fill_last <= w_last;
                                r_clr_resp  <= 1'b1;
                                r_state     <= S_CLR;
                            end
                            pwlc_pkg::CMD_SET: begin
                                r_status <= w_set_rej;
                                r_state  <= w_set_rej ? S_RESP : S_DIVK;
                            end
                            pwlc_pkg::CMD_REMOVE: begin
                                r_status <= w_rm_rej;
                                r_state  <= w_rm_rej ? S_RESP : S_RMCHK;
                            end
                            pwlc_pkg::CMD_GET: begin
                                r_status <= !w_in_dom;
                                r_state  <= w_in_dom ? S_GETRD : S_RESP;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_GETRD: begin
                    r_out_value <= tbl_rdata;
                    r_state     <= S_RESP;
                end
                S_RMCHK: begin
                    if (!mark_rdata) begin
                        r_status <= 1'b1;
                        r_state  <= S_RESP;
                    end else begin
                        r_flow     <= FL_RM_PREV;
                        r_dir_next <= 1'b0;
                        r_scan     <= r_idx - IW'(1);
                        r_chk_vld  <= 1'b0;
                        r_state    <= S_SRCH;
                    end
                end
                S_DIVK: begin
                    if (div_rsp.done) begin
                        r_idx   <= w_kc_off[IW-1:0];
                        r_state <= S_SETRD;
                    end
                end
                S_SETRD: r_state <= S_SETCHK;
                S_SETCHK: begin
                    r_chk_vld <= 1'b0;
                    if (w_same || (w_last == '0)) begin
                        r_state <= S_RESP;
                    end else if (r_idx != '0) begin
                        r_flow     <= FL_SET_PREV;
                        r_dir_next <= 1'b0;
                        r_scan     <= r_idx - IW'(1);
                        r_state    <= S_SRCH;
                    end else begin
                        r_flow     <= FL_SET_NEXT;
                        r_dir_next <= 1'b1;
                        r_scan     <= r_idx + IW'(1);
                        r_state    <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (w_found) begin
                        r_chk_vld <= 1'b0;
                        unique case (r_flow)
                            FL_SET_PREV: begin
                                r_a     <= w_found_idx;
                                r_b     <= r_idx;
                                r_state <= S_RDA;
                            end
                            FL_SET_NEXT: begin
                                r_a     <= r_idx;
                                r_b     <= w_found_idx;
                                r_state <= S_RDA;
                            end
                            FL_RM_PREV: begin
                                r_a        <= w_found_idx;
                                r_flow     <= FL_RM_NEXT;
                                r_dir_next <= 1'b1;
                                r_scan     <= r_idx + IW'(1);
                            end
                            FL_RM_NEXT: begin
                                r_b     <= w_found_idx;
                                r_state <= S_RDA;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end else begin
                        r_chk_vld  <= 1'b1;
                        r_chk_addr <= r_scan;
                        r_scan     <= r_dir_next ? (r_scan + IW'(1)) : (r_scan - IW'(1));
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_va    <= tbl_rdata;
                    r_state <= S_SEGSET;
                end
                S_SEGSET: begin
                    r_neg   <= w_d[VW];
                    r_len   <= w_len;
                    r_state <= S_SEGDIV;
                end
                S_SEGDIV: begin
                    if (div_rsp.done) begin
                        r_dq    <= div_rsp.quot;
                        r_dr    <= div_rsp.rem[IW-1:0];
                        r_q     <= '0;
                        r_r     <= '0;
                        r_i     <= r_a;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_i <= r_i + IW'(1);
                    if (w_rge) begin
                        r_r <= IW'(w_rsum - {1'b0, r_len});
                        r_q <= r_q + r_dq + VW'(1);
                    end else begin
                        r_r <= w_rsum[IW-1:0];
                        r_q <= r_q + r_dq;
                    end
                    if (r_i == r_b) begin
                        if (r_flow == FL_SET_PREV && r_idx != w_last) begin
                            r_flow     <= FL_SET_NEXT;
                            r_dir_next <= 1'b1;
                            r_scan     <= r_idx + IW'(1);
                            r_chk_vld  <= 1'b0;
                            r_state    <= S_SRCH;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    r_done     <= 1'b1;
                    r_clr_resp <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pwlc_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    pwlc_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    pwlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    `PWLC_ASSERT_NXT(a_accept_busy, w_accept, busy, "accepted word did not raise busy")
    `PWLC_ASSERT_NXT(a_done_single, o_done, !o_done, "result strobe held over two cycles")
    `PWLC_ASSERT_IMP(a_reject_zero, o_done && o_status, o_value == '0, "rejected word with value")
    `PWLC_ASSERT_IMP(a_fill_bound, r_state == S_FILL, (r_i <= r_b) && (r_a < r_b), "fill out of segment")

endmodule

### rtl/core/pwlc_ram.sv
module pwlc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/pwlc_div.sv
// Restoring divider, one quotient bit per cycle.
module pwlc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwlc_pkg::t_div_req i_req,
    output pwlc_pkg::t_div_rsp o_rsp
);

    localparam int W  = pwlc_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvs;

    logic [W:0]    w_trial;
    logic          w_ge;
    logic [W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quot[W-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[W-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule
